FILE: rtl/htlp_pkg.sv
// package for the hash table with linear probing unit
// holds field widths, operation and status codes, fsm states and the
// controller/datapath command and status structs; no dependencies
package htlp_pkg;

	// fixed field widths of the stream payloads
	localparam int FUNC_W    = 2;
	localparam int KEY_IN_W  = 40;
	localparam int NAME_W    = 64;
	localparam int STATUS_W  = 3;
	localparam int SLOT_W    = 4;

	// packed payload layout, lowest field first
	localparam int IN_FUNC_LO = 0;
	localparam int IN_KEY_LO  = IN_FUNC_LO + FUNC_W;
	localparam int IN_NAME_LO = IN_KEY_LO + KEY_IN_W;
	localparam int IN_USED_W  = IN_NAME_LO + NAME_W;
	localparam int S_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

	localparam int OUT_USED_W = STATUS_W + SLOT_W + NAME_W;
	localparam int M_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_MISSING  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_DELETED  = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_PLACE,
		S_CHECK,
		S_FREE,
		S_SCAN,
		S_RESP
	} htlp_state_t;

	typedef enum logic [2:0] {
		RES_INS,
		RES_FULL,
		RES_FOUND,
		RES_DEL,
		RES_MISS
	} htlp_res_t;

	typedef struct packed {
		logic      load;          // capture the input transaction
		logic      hash_step;     // one radix-4 step of key mod slots
		logic      put_new_home;  // write the new entry at its home slot
		logic      rd_home;       // read the entry at the home slot
		logic      free_init;     // probe pointer to home + 1
		logic      free_step;     // advance the probe pointer
		logic      put_new_ptr;   // write the new entry at the probe slot
		logic      put_old_ptr;   // write the displaced entry at the probe slot
		logic      scan_issue;    // read the next slot of a lookup or delete scan
		logic      del_clear;     // clear the valid bit of the matched slot
		logic      res_load;      // load the result register
		htlp_res_t res_sel;
	} htlp_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] in_func;
		logic              full;
		logic              hash_last;
		logic              home_free;
		logic              home_foreign;
		logic              free_hit;
		logic              hit;
		logic              last_cmp;
		logic              scan_end;
		logic              out_free;
	} htlp_stat_t;

endpackage

FILE: rtl/htlp_ctrl.sv
// controller state machine of the hash table unit
// sequences hash, placement, free-slot probe and lookup or delete scan; uses htlp_pkg
module htlp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  htlp_pkg::htlp_stat_t stat,
	output logic                s_tready,
	output htlp_pkg::htlp_cmd_t  cmd
);
	import htlp_pkg::*;

	htlp_state_t state_q, state_nxt;
	htlp_res_t   res_q, res_nxt;
	logic        move_old_q, move_old_nxt;
	logic        del_q, del_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			res_q      <= RES_MISS;
			move_old_q <= 1'b0;
			del_q      <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			res_q      <= res_nxt;
			move_old_q <= move_old_nxt;
			del_q      <= del_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		res_nxt      = res_q;
		move_old_nxt = move_old_q;
		del_nxt      = del_q;
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.res_sel  = res_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					unique case (stat.in_func) inside
						FN_INSERT: begin
							if (stat.full) begin
								res_nxt   = RES_FULL;
								state_nxt = S_RESP;
							end else begin
								state_nxt = S_HASH;
							end
						end
						FN_LOOKUP, FN_DELETE: begin
							del_nxt   = (stat.in_func == FN_DELETE);
							state_nxt = S_SCAN;
						end
						default: begin
							res_nxt   = RES_MISS;
							state_nxt = S_RESP;
						end
					endcase
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (stat.hash_last) begin
					state_nxt = S_PLACE;
				end
			end
			S_PLACE: begin
				if (stat.home_free) begin
					cmd.put_new_home = 1'b1;
					res_nxt          = RES_INS;
					state_nxt        = S_RESP;
				end else begin
					cmd.rd_home = 1'b1;
					state_nxt   = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.free_init = 1'b1;
				// occupant from another home is displaced to the next free slot
				cmd.put_new_home = stat.home_foreign;
				move_old_nxt     = stat.home_foreign;
				state_nxt        = S_FREE;
			end
			S_FREE: begin
				if (stat.free_hit) begin
					cmd.put_old_ptr = move_old_q;
					cmd.put_new_ptr = !move_old_q;
					res_nxt         = RES_INS;
					state_nxt       = S_RESP;
				end else begin
					cmd.free_step = 1'b1;
				end
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.del_clear = del_q;
					res_nxt       = del_q ? RES_DEL : RES_FOUND;
					state_nxt     = S_RESP;
				end else if (stat.last_cmp) begin
					res_nxt   = RES_MISS;
					state_nxt = S_RESP;
				end else begin
					cmd.scan_issue = !stat.scan_end;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/htlp_datapath.sv
// datapath of the hash table unit: slot memory, valid bits, entry count,
// iterative key-mod-slots unit, probe pointer and result register; uses htlp_pkg
module htlp_datapath #(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [htlp_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic                              m_tready,
	input  htlp_pkg::htlp_cmd_t               cmd,
	output htlp_pkg::htlp_stat_t              stat,
	output logic                              m_tvalid,
	output logic [htlp_pkg::M_TDATA_W-1:0]    m_tdata
);
	import htlp_pkg::*;

	localparam int IW     = $clog2(SLOTS);
	localparam int CW     = $clog2(SLOTS + 1);
	localparam int KW     = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
	localparam int KP     = KW + (KW % 2);
	localparam int HSTEPS = KP / 2;
	localparam int HCW    = $clog2(HSTEPS + 1);
	localparam int RW     = IW + 3;

	localparam logic [IW-1:0]  LAST_IDX  = IW'(SLOTS - 1);
	localparam logic [CW-1:0]  SLOTS_CNT = CW'(SLOTS);
	localparam logic [RW-1:0]  MOD1      = RW'(SLOTS);
	localparam logic [RW-1:0]  MOD2      = RW'(2 * SLOTS);
	localparam logic [HCW-1:0] HSTEPS_C  = HCW'(HSTEPS);

	// input fields
	logic [FUNC_W-1:0]   in_func;
	logic [KEY_IN_W-1:0] in_key;
	logic [NAME_W-1:0]   in_name;

	assign in_func = s_tdata[IN_FUNC_LO +: FUNC_W];
	assign in_key  = s_tdata[IN_KEY_LO +: KEY_IN_W];
	assign in_name = s_tdata[IN_NAME_LO +: NAME_W];

	// captured operation
	logic [KW-1:0]     key_q;
	logic [NAME_W-1:0] name_q;

	// hash unit
	logic [KP-1:0]  hsh_q, hsh_init;
	logic [HCW-1:0] hcnt_q;
	logic [IW-1:0]  rem_q;
	logic [RW-1:0]  h_t0, h_t1, h_t2;

	// slot storage
	logic [KW-1:0]     mem_key  [SLOTS];
	logic [NAME_W-1:0] mem_name [SLOTS];
	logic [IW-1:0]     mem_home [SLOTS];
	logic [SLOTS-1:0]  valid_q;
	logic [CW-1:0]     count_q;

	// read stage
	logic [KW-1:0]     rd_key_q;
	logic [NAME_W-1:0] rd_name_q;
	logic [IW-1:0]     rd_home_q;
	logic [IW-1:0]     rd_idx_q;
	logic              rd_vld_q;
	logic              rd_pend_q;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;

	// write port
	logic              wr_en, wr_new;
	logic [IW-1:0]     wr_addr;
	logic [KW-1:0]     wr_key;
	logic [NAME_W-1:0] wr_name;
	logic [IW-1:0]     wr_home;

	// probe pointer
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] ptr_inc, rem_inc;
	logic          issued_all_q;
	logic [IW-1:0] where_q;

	// result register
	logic                m_tvalid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [NAME_W-1:0]   found_q;
	logic [IW+SLOT_W-1:0] where_ext, rd_idx_ext;

	assign hsh_init = KP'(in_key[KW-1:0]);

	// radix-4 remainder step, stays below slots after two conditional subtracts
	always_comb begin
		h_t0 = RW'({rem_q, hsh_q[KP-1 -: 2]});
		h_t1 = (h_t0 >= MOD2) ? (h_t0 - MOD2) : h_t0;
		h_t2 = (h_t1 >= MOD1) ? (h_t1 - MOD1) : h_t1;
	end

	assign ptr_inc = (ptr_q == LAST_IDX) ? '0 : (ptr_q + IW'(1));
	assign rem_inc = (rem_q == LAST_IDX) ? '0 : (rem_q + IW'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= in_key[KW-1:0];
			name_q <= in_name;
			hsh_q  <= hsh_init;
		end else if (cmd.hash_step) begin
			hsh_q <= hsh_q << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
			rem_q  <= '0;
		end else if (cmd.load) begin
			hcnt_q <= HSTEPS_C;
			rem_q  <= '0;
		end else if (cmd.hash_step) begin
			hcnt_q <= hcnt_q - HCW'(1);
			rem_q  <= h_t2[IW-1:0];
		end
	end

	// memory write: new entry or the displaced one held in the read stage
	assign wr_new  = cmd.put_new_home | cmd.put_new_ptr;
	assign wr_en   = wr_new | cmd.put_old_ptr;
	assign wr_addr = cmd.put_new_home ? rem_q : ptr_q;
	assign wr_key  = cmd.put_old_ptr ? rd_key_q : key_q;
	assign wr_name = cmd.put_old_ptr ? rd_name_q : name_q;
	assign wr_home = cmd.put_old_ptr ? rd_home_q : rem_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_key[wr_addr]  <= wr_key;
			mem_name[wr_addr] <= wr_name;
			mem_home[wr_addr] <= wr_home;
		end
	end

	assign rd_en   = cmd.scan_issue | cmd.rd_home;
	assign rd_addr = cmd.scan_issue ? ptr_q : rem_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q  <= mem_key[rd_addr];
			rd_name_q <= mem_name[rd_addr];
			rd_home_q <= mem_home[rd_addr];
			rd_idx_q  <= rd_addr;
			rd_vld_q  <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= cmd.scan_issue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.del_clear) begin
				valid_q[rd_idx_q] <= 1'b0;
			end
			if (wr_new) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.del_clear && count_q != '0) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			issued_all_q <= 1'b0;
			where_q      <= '0;
		end else begin
			if (cmd.load) begin
				ptr_q        <= '0;
				issued_all_q <= 1'b0;
			end else if (cmd.free_init) begin
				ptr_q <= rem_inc;
			end else if (cmd.free_step || cmd.scan_issue) begin
				ptr_q <= ptr_inc;
			end
			if (cmd.scan_issue && ptr_q == LAST_IDX) begin
				issued_all_q <= 1'b1;
			end
			if (cmd.put_new_home) begin
				where_q <= rem_q;
			end else if (cmd.put_new_ptr) begin
				where_q <= ptr_q;
			end
		end
	end

	// result register, slot index keeps its low four bits
	assign where_ext  = (IW + SLOT_W)'(where_q);
	assign rd_idx_ext = (IW + SLOT_W)'(rd_idx_q);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			found_q <= '0;
			slot_q  <= '0;
			case (cmd.res_sel)
				RES_INS: begin
					status_q <= STAT_INSERTED;
					slot_q   <= where_ext[SLOT_W-1:0];
				end
				RES_FULL: begin
					status_q <= STAT_FULL;
				end
				RES_FOUND: begin
					status_q <= STAT_FOUND;
					slot_q   <= rd_idx_ext[SLOT_W-1:0];
					found_q  <= rd_name_q;
				end
				RES_DEL: begin
					status_q <= STAT_DELETED;
					slot_q   <= rd_idx_ext[SLOT_W-1:0];
				end
				default: begin
					status_q <= STAT_MISSING;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({found_q, slot_q, status_q});

	always_comb begin
		stat.in_func      = in_func;
		stat.full         = (count_q >= SLOTS_CNT);
		stat.hash_last    = (hcnt_q == HCW'(1));
		stat.home_free    = !valid_q[rem_q];
		stat.home_foreign = (rd_home_q != rem_q);
		stat.free_hit     = !valid_q[ptr_q];
		stat.hit          = rd_pend_q && rd_vld_q && (rd_key_q == key_q);
		stat.last_cmp     = rd_pend_q && (rd_idx_q == LAST_IDX);
		stat.scan_end     = issued_all_q;
		stat.out_free     = !m_tvalid_q || m_tready;
	end

endmodule

FILE: rtl/hash_table_linear_probe_unit.sv
// hash table with linear probing and replacement: one transaction at a time
// insert: accept, hash the key mod SLOTS, place at the home slot or, when it is taken,
//   check its occupant and probe for a free slot; then load the result
// lookup, delete: accept, scan from slot 0, load the result; full insert, bad opcode: accept, result
// the next transaction is taken in the cycle after the result loads; output stalls hold the result
// reset (arst_n low) empties the table at once: valid bits and entry count clear
module hash_table_linear_probe_unit #(
	parameter int SLOTS    = 16,   // number of table slots, 2 to 64
	parameter int KEY_BITS = 40    // key bits that take part (capped at 40), 16 to 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// operation stream, tdata from lsb: func[1:0], key[39:0], client_name[63:0]
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [htlp_pkg::S_TDATA_W-1:0] s_tdata,
	// result stream, tdata from lsb: status[2:0], slot_index[3:0], found_name[63:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [htlp_pkg::M_TDATA_W-1:0] m_tdata
);
	import htlp_pkg::*;

	// command and status between the sequencer and the datapath
	htlp_cmd_t  cmd;
	htlp_stat_t stat;

	// sequencer: takes a transaction only when idle, walks hash, placement,
	// probe or scan as the operation needs, then waits in its result state until
	// the output register is free; no new transaction is taken while it waits there
	htlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	// datapath: slot memory with registered read, valid bits in flops,
	// entry count, remainder unit, probe pointer and output register
	htlp_datapath #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: verif/hash_table_linear_probe_unit_tb.sv
// self-checking testbench for hash_table_linear_probe_unit
// needs rtl/htlp_pkg.sv, htlp_ctrl.sv, htlp_datapath.sv, hash_table_linear_probe_unit.sv;
// drives op transactions, predicts results from a shadow table, checks the result stream
`timescale 1ns / 100ps

module hash_table_linear_probe_unit_tb;
	import htlp_pkg::*;

	localparam int NSLOTS     = 16;
	localparam int KEY_W      = 40;
	localparam int RAND_OPS   = 1700;
	localparam int CALM_TAIL  = 200;   // last random ops run with no idling
	localparam int QUIET_WAIT = 60;    // cycles allowed after the last result
	localparam int STALL_MAX  = 1000;  // cycles with no transaction before giving up

	// func 3 is not an operation; the block answers it as a miss
	localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

	localparam logic [KEY_W-1:0]  KEY_TOP  = {KEY_W{1'b1}};
	localparam logic [NAME_W-1:0] NAME_TOP = {NAME_W{1'b1}};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [NAME_W-1:0]   name;
	} result_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [NAME_W-1:0] name;
		logic              fixed;   // expected result typed in the row
		result_t           res;
	} op_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // func[1:0], key[39:0], client_name[63:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // status[2:0], slot_index[3:0], found_name[63:0]

	// shadow copy of the slot table
	logic              tbl_valid [NSLOTS];
	logic [KEY_W-1:0]  tbl_key   [NSLOTS];
	logic [NAME_W-1:0] tbl_name  [NSLOTS];
	int                tbl_count;

	result_t expected_results [$];
	op_row_t directed_ops [$];
	int      err_count   = 0;
	int      stall_left  = 0;
	int      quiet_ticks = 0;
	bit      idle_on     = 1'b1;

	hash_table_linear_probe_unit #(
		.SLOTS    (NSLOTS),
		.KEY_BITS (KEY_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int slot_home(logic [KEY_W-1:0] k);
		return int'(k % NSLOTS);
	endfunction

	// first free slot after start, wrapping around the table
	function automatic int next_free_slot(int start);
		int s;
		s = start;
		for (int n = 0; n < NSLOTS; n++) begin
			s = (s + 1) % NSLOTS;
			if (!tbl_valid[s])
				return s;
		end
		return start;
	endfunction

	// lowest valid slot holding k, or NSLOTS when absent
	function automatic int lowest_match(logic [KEY_W-1:0] k);
		for (int s = 0; s < NSLOTS; s++)
			if (tbl_valid[s] && tbl_key[s] == k)
				return s;
		return NSLOTS;
	endfunction

	// applies one operation to the shadow table and returns its result
	function automatic result_t predict_table_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
		logic [NAME_W-1:0] nm);
		result_t           r;
		int                h;
		int                s;
		logic [KEY_W-1:0]  old_key;
		logic [NAME_W-1:0] old_name;
		r.status = STAT_MISSING;
		r.slot   = '0;
		r.name   = '0;
		case (f)
			FN_INSERT: begin
				if (tbl_count >= NSLOTS) begin
					r.status = STAT_FULL;
				end else begin
					h = slot_home(k);
					if (!tbl_valid[h]) begin
						s = h;
					end else if (slot_home(tbl_key[h]) != h) begin
						// squatter from another home is pushed to the next free slot
						old_key  = tbl_key[h];
						old_name = tbl_name[h];
						s = next_free_slot(h);
						tbl_valid[s] = 1'b1;
						tbl_key[s]   = old_key;
						tbl_name[s]  = old_name;
						s = h;
					end else begin
						s = next_free_slot(h);
					end
					tbl_valid[s] = 1'b1;
					tbl_key[s]   = k;
					tbl_name[s]  = nm;
					tbl_count++;
					r.status = STAT_INSERTED;
					r.slot   = SLOT_W'(s);
				end
			end
			FN_LOOKUP: begin
				s = lowest_match(k);
				if (s < NSLOTS) begin
					r.status = STAT_FOUND;
					r.slot   = SLOT_W'(s);
					r.name   = tbl_name[s];
				end
			end
			FN_DELETE: begin
				s = lowest_match(k);
				if (s < NSLOTS) begin
					// only the valid bit goes; key and name stay behind unread
					tbl_valid[s] = 1'b0;
					if (tbl_count > 0)
						tbl_count--;
					r.status = STAT_DELETED;
					r.slot   = SLOT_W'(s);
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- sender

	// present one op transaction, hold it until accepted, then optionally go idle
	task automatic send_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k, logic [NAME_W-1:0] nm,
		int gap, logic fixed, result_t fixed_res);
		logic [S_TDATA_W-1:0] word;
		result_t              pred;
		word = '0;
		word[IN_FUNC_LO +: FUNC_W]   = f;
		word[IN_KEY_LO  +: KEY_IN_W] = k;
		word[IN_NAME_LO +: NAME_W]   = nm;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		// accepted at this edge: the shadow table moves on with it
		pred = predict_table_op(f, k, nm);
		expected_results.push_back(fixed ? fixed_res : pred);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop valid and hold off until every pending result has arrived
	task automatic wait_results_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_row(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k, logic [NAME_W-1:0] nm,
		logic fixed, logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl, logic [NAME_W-1:0] fn);
		op_row_t row;
		row.func       = f;
		row.key        = k;
		row.name       = nm;
		row.fixed      = fixed;
		row.res.status = st;
		row.res.slot   = sl;
		row.res.name   = fn;
		directed_ops.push_back(row);
	endtask

	// ---------------------------------------------------------------- receiver

	// result side backpressure: random stall bursts, started only while idle_on is set
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare every result transaction with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got.status = m_tdata[0 +: STATUS_W];
			got.slot   = m_tdata[STATUS_W +: SLOT_W];
			got.name   = m_tdata[STATUS_W + SLOT_W +: NAME_W];
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing pending: status %0d slot %0d",
					got.status, got.slot);
				err_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					err_count++;
				end
				if (got.slot !== want.slot) begin
					$error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
					err_count++;
				end
				if (got.name !== want.name) begin
					$error("found_name: expected %h, actual %h", want.name, got.name);
					err_count++;
				end
			end
		end
	end

	// watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
			quiet_ticks <= 0;
		end else if (quiet_ticks >= STALL_MAX) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_ticks <= quiet_ticks + 1;
		end
	end

	// ---------------------------------------------------------------- main flow

	initial begin
		int                i;
		int                gap;
		int                pick;
		int                s;
		bit                filling;
		logic [FUNC_W-1:0] f;
		logic [KEY_W-1:0]  k;
		logic [NAME_W-1:0] nm;
		logic [63:0]       wide;
		op_row_t           row;
		result_t           none;

		none = '0;
		for (i = 0; i < NSLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i]   = '0;
			tbl_name[i]  = '0;
		end
		tbl_count = 0;

		// directed ops; fixed rows carry the answer, the rest go to the predictor
		add_row(FN_LOOKUP, '0, '0, 1'b1, STAT_MISSING, 4'd0, '0);           // empty table
		add_row(FN_SPARE, KEY_TOP, NAME_TOP, 1'b1, STAT_MISSING, 4'd0, '0);  // unused opcode
		add_row(FN_INSERT, '0, NAME_TOP, 1'b1, STAT_INSERTED, 4'd0, '0);
		add_row(FN_INSERT, KEY_TOP, '0, 1'b1, STAT_INSERTED, 4'd15, '0);
		add_row(FN_INSERT, 40'd16, 64'h4a4f_4e45_5300_0001, 1'b0, '0, '0, '0); // home taken
		add_row(FN_INSERT, 40'd1, 64'h534d_4954_4800_0002, 1'b0, '0, '0, '0);  // displaces 16
		add_row(FN_INSERT, 40'd31, 64'h4c45_4500_0000_0003, 1'b0, '0, '0, '0); // probe wraps
		add_row(FN_LOOKUP, '0, '0, 1'b1, STAT_FOUND, 4'd0, NAME_TOP);
		add_row(FN_LOOKUP, KEY_TOP, NAME_TOP, 1'b1, STAT_FOUND, 4'd15, '0);
		add_row(FN_INSERT, '0, 64'h4455_5000_0000_0004, 1'b0, '0, '0, '0);    // duplicate key
		add_row(FN_DELETE, '0, '0, 1'b1, STAT_DELETED, 4'd0, '0);            // lowest match
		add_row(FN_LOOKUP, '0, '0, 1'b0, '0, '0, '0);                        // duplicate left
		for (i = 0; i < 11; i++)                                             // fill the table
			add_row(FN_INSERT, 40'h80_0000_0000 + 40'(i * 3), 64'h0123_4567_89ab_cdef ^ 64'(i),
				1'b0, '0, '0, '0);
		add_row(FN_INSERT, 40'd7, NAME_TOP, 1'b1, STAT_FULL, 4'd0, '0);      // refused when full
		add_row(FN_DELETE, KEY_TOP, '0, 1'b0, '0, '0, '0);

		// reset held low from time zero, released on a falling edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_ops[j]) begin
			row = directed_ops[j];
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
			send_op(row.func, row.key, row.name, gap, row.fixed, row.res);
		end
		wait_results_drained();

		// random ops: phases that lean toward filling, then toward draining the table
		for (i = 0; i < RAND_OPS; i++) begin
			idle_on = (i < RAND_OPS - CALM_TAIL) && ((i / 100) % 3 != 2);
			filling = ((i / 120) % 2 == 0);

			pick = $urandom_range(0, 99);
			if (pick < 3)
				f = FN_SPARE;
			else if (pick < (filling ? 63 : 23))
				f = FN_INSERT;
			else if (pick < (filling ? 88 : 53))
				f = FN_LOOKUP;
			else
				f = FN_DELETE;

			// keys mostly from the table so lookups and deletes hit; small keys collide
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				s = $urandom_range(0, NSLOTS - 1);
				k = tbl_valid[s] ? tbl_key[s] : KEY_W'($urandom_range(0, 63));
			end else if (pick < 8) begin
				k = KEY_W'($urandom_range(0, 63));
			end else begin
				wide = {$urandom(), $urandom()};
				k = wide[KEY_W-1:0];
			end
			nm = {$urandom(), $urandom()};

			gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
			send_op(f, k, nm, gap, 1'b0, none);

			// now and then hold the sender until the result stream has caught up
			if (i < RAND_OPS - CALM_TAIL && i % 400 == 399)
				wait_results_drained();
		end

		wait_results_drained();
		repeat (QUIET_WAIT) @(negedge clk);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
